// ===== design/nmad_pkg.sv =====
// ----------------------------------------------------------------------------
// nmad_pkg
// shared widths, state codes and unit request/response types
// ----------------------------------------------------------------------------
package nmad_pkg;

  localparam int unsigned Wide           = 64;
  localparam int unsigned CntW           = $clog2(Wide);
  localparam int unsigned CountW         = 31;
  localparam int unsigned DivisorW       = 31;
  localparam int unsigned ResultW        = 62;
  localparam int unsigned DivisorBitsDef = 31;

  typedef logic [Wide-1:0] word_t;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_MN   = 9'b000000010,
    S_GCD  = 9'b000000100,
    S_QUO  = 9'b000001000,
    S_CHK  = 9'b000010000,
    S_MUL  = 9'b000100000,
    S_DIV  = 9'b001000000,
    S_UPD  = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_e;

  typedef struct packed {
    logic  start;
    word_t op_a;
    word_t op_b;
  } unit_req_t;

  typedef struct packed {
    logic  done;
    word_t res_a;
    word_t res_b;
  } unit_rsp_t;

endpackage

// ===== design/nmad_if.sv =====
// ----------------------------------------------------------------------------
// nmad channel interfaces
// valid/ready channels for request and result items
// ----------------------------------------------------------------------------
interface nmad_in_if;
  logic        valid;
  logic        ready;
  logic [30:0] count_n;
  logic [30:0] divisor_a;
  logic [30:0] divisor_b;
  logic [30:0] divisor_c;
  modport source (output valid, count_n, divisor_a, divisor_b, divisor_c, input ready);
  modport sink (input valid, count_n, divisor_a, divisor_b, divisor_c, output ready);
endinterface

interface nmad_out_if;
  logic        valid;
  logic        ready;
  logic [61:0] nth_value;
  modport source (output valid, nth_value, input ready);
  modport sink (input valid, nth_value, output ready);
endinterface

// ===== design/nmad_div.sv =====
// ----------------------------------------------------------------------------
// nmad_div
// restoring divider, one quotient bit per cycle; res_a quotient, res_b remainder
// ----------------------------------------------------------------------------
module nmad_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  nmad_pkg::unit_req_t req_i,
  output nmad_pkg::unit_rsp_t rsp_o
);
  import nmad_pkg::*;

  logic            busy_q, done_q;
  logic [CntW-1:0] cnt_q;
  word_t           rem_q, quo_q, dvs_q;
  logic [Wide:0]   rem_sh;
  logic            fits;

  assign rem_sh = {rem_q, quo_q[Wide-1]};
  assign fits   = rem_sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CntW'(Wide - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.op_a;
      dvs_q <= req_i.op_b;
    end else if (busy_q) begin
      rem_q <= fits ? Wide'(rem_sh - {1'b0, dvs_q}) : rem_sh[Wide-1:0];
      quo_q <= {quo_q[Wide-2:0], fits};
    end
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.res_a = quo_q;
  assign rsp_o.res_b = rem_q;
endmodule

// ===== design/nmad_mul.sv =====
// ----------------------------------------------------------------------------
// nmad_mul
// shift-add multiplier, one multiplier bit per cycle, low word kept
// ----------------------------------------------------------------------------
module nmad_mul (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  nmad_pkg::unit_req_t req_i,
  output nmad_pkg::unit_rsp_t rsp_o
);
  import nmad_pkg::*;

  logic            busy_q, done_q;
  logic [CntW-1:0] cnt_q;
  word_t           acc_q, mcd_q, mpl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CntW'(Wide - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      acc_q <= '0;
      mcd_q <= req_i.op_a;
      mpl_q <= req_i.op_b;
    end else if (busy_q) begin
      if (mpl_q[0]) acc_q <= acc_q + mcd_q;
      mcd_q <= {mcd_q[Wide-2:0], 1'b0};
      mpl_q <= {1'b0, mpl_q[Wide-1:1]};
    end
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.res_a = acc_q;
  assign rsp_o.res_b = mpl_q;
endmodule

// ===== design/nth_multiple_of_any_divisor_unit.sv =====
// ----------------------------------------------------------------------------
// nth_multiple_of_any_divisor_unit
// n-th positive integer divisible by any of three divisors
// ----------------------------------------------------------------------------
// One item at a time: the unit is not ready from acceptance until its result
// is taken. Each division occupies the shared restoring divider, and each
// multiply the shift-add multiplier, until it is done. An item costs one
// multiply for the search bound, four least common multiples (Euclid steps,
// one quotient, one bound check, at most one multiply each), then seven
// divisions per binary search step over up to 62 steps. A count of one skips
// the search, leaving only the bound and the least common multiples. Zero
// count or all-zero divisors give a result of zero straight from idle.
module nth_multiple_of_any_divisor_unit #(
  parameter int unsigned DIVISOR_BITS = nmad_pkg::DivisorBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  nmad_in_if.sink    in_i,
  nmad_out_if.source out_o
);
  import nmad_pkg::*;

  state_e    state_q, state_d;
  logic      pend_q, pend_d;
  logic [1:0] lidx_q, lidx_d;
  logic [2:0] k_q, k_d;
  word_t a_q, a_d, b_q, b_d, c_q, c_d, n_q, n_d;
  word_t lo_q, lo_d, hi_q, hi_d, cap_q, cap_d;
  word_t ab_q, ab_d, ac_q, ac_d, bc_q, bc_d, abc_q, abc_d;
  word_t gx_q, gx_d, gy_q, gy_d, qt_q, qt_d, acc_q, acc_d, res_q, res_d;

  unit_req_t div_req, mul_req;
  unit_rsp_t div_rsp, mul_rsp;

  word_t ia, ib, ic, in_n, any, m, mid, lx, ly, dsel, lres, nlo, nhi;
  logic  store;

  nmad_div u_div (.clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp));
  nmad_mul u_mul (.clk_i, .rst_ni, .req_i(mul_req), .rsp_o(mul_rsp));

  assign ia   = Wide'(in_i.divisor_a[DIVISOR_BITS-1:0]);
  assign ib   = Wide'(in_i.divisor_b[DIVISOR_BITS-1:0]);
  assign ic   = Wide'(in_i.divisor_c[DIVISOR_BITS-1:0]);
  assign in_n = Wide'(in_i.count_n);
  assign any  = (ia != '0) ? ia : ((ib != '0) ? ib : ic);

  assign in_i.ready      = (state_q == S_IDLE);
  assign out_o.valid     = (state_q == S_OUT);
  assign out_o.nth_value = res_q[ResultW-1:0];

  assign mid = lo_q + ((hi_q - lo_q) >> 1);

  always_comb begin
    m = a_q;
    if (b_q < m) m = b_q;
    if (c_q < m) m = c_q;
  end

  function automatic word_t pick_x(logic [1:0] i, word_t a, word_t b, word_t ab);
    case (i)
      2'd0, 2'd1: pick_x = a;
      2'd2:       pick_x = b;
      default:    pick_x = ab;
    endcase
  endfunction

  function automatic word_t pick_y(logic [1:0] i, word_t b, word_t c);
    case (i)
      2'd0:    pick_y = b;
      default: pick_y = c;
    endcase
  endfunction

  assign lx = pick_x(lidx_q, a_q, b_q, ab_q);
  assign ly = pick_y(lidx_q, b_q, c_q);

  always_comb begin
    case (k_q)
      3'd0:    dsel = a_q;
      3'd1:    dsel = b_q;
      3'd2:    dsel = c_q;
      3'd3:    dsel = abc_q;
      3'd4:    dsel = ab_q;
      3'd5:    dsel = ac_q;
      default: dsel = bc_q;
    endcase
  end

  assign nlo = (acc_q < n_q) ? mid + 1'b1 : lo_q;
  assign nhi = (acc_q < n_q) ? hi_q : mid;

  always_comb begin
    state_d = state_q;
    pend_d  = pend_q;
    lidx_d  = lidx_q;
    k_d     = k_q;
    a_d = a_q; b_d = b_q; c_d = c_q; n_d = n_q;
    lo_d = lo_q; hi_d = hi_q; cap_d = cap_q;
    ab_d = ab_q; ac_d = ac_q; bc_d = bc_q; abc_d = abc_q;
    gx_d = gx_q; gy_d = gy_q; qt_d = qt_q; acc_d = acc_q; res_d = res_q;
    div_req = '0;
    mul_req = '0;
    store   = 1'b0;
    lres    = cap_q;

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          if (in_n == '0 || any == '0) begin
            res_d   = '0;
            state_d = S_OUT;
          end else begin
            a_d     = (ia != '0) ? ia : any;
            b_d     = (ib != '0) ? ib : any;
            c_d     = (ic != '0) ? ic : any;
            n_d     = in_n;
            pend_d  = 1'b0;
            state_d = S_MN;
          end
        end
      end
      S_MN: begin
        mul_req.op_a = m;
        mul_req.op_b = n_q;
        if (!pend_q) begin
          mul_req.start = 1'b1;
          pend_d = 1'b1;
        end else if (mul_rsp.done) begin
          pend_d  = 1'b0;
          lo_d    = m;
          hi_d    = mul_rsp.res_a;
          cap_d   = mul_rsp.res_a + 1'b1;
          lidx_d  = 2'd0;
          gx_d    = a_q;
          gy_d    = b_q;
          state_d = S_GCD;
        end
      end
      S_GCD: begin
        div_req.op_a = gx_q;
        div_req.op_b = gy_q;
        if (gy_q == '0) begin
          state_d = S_QUO;
        end else if (!pend_q) begin
          div_req.start = 1'b1;
          pend_d = 1'b1;
        end else if (div_rsp.done) begin
          pend_d = 1'b0;
          gx_d   = gy_q;
          gy_d   = div_rsp.res_b;
        end
      end
      S_QUO: begin
        div_req.op_a = lx;
        div_req.op_b = gx_q;
        if (!pend_q) begin
          div_req.start = 1'b1;
          pend_d = 1'b1;
        end else if (div_rsp.done) begin
          pend_d  = 1'b0;
          qt_d    = div_rsp.res_a;
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        div_req.op_a = cap_q;
        div_req.op_b = ly;
        if (!pend_q) begin
          div_req.start = 1'b1;
          pend_d = 1'b1;
        end else if (div_rsp.done) begin
          pend_d = 1'b0;
          if (qt_q > div_rsp.res_a) begin
            store = 1'b1;
          end else begin
            state_d = S_MUL;
          end
        end
      end
      S_MUL: begin
        mul_req.op_a = qt_q;
        mul_req.op_b = ly;
        if (!pend_q) begin
          mul_req.start = 1'b1;
          pend_d = 1'b1;
        end else if (mul_rsp.done) begin
          pend_d = 1'b0;
          lres   = (mul_rsp.res_a > cap_q) ? cap_q : mul_rsp.res_a;
          store  = 1'b1;
        end
      end
      S_DIV: begin
        div_req.op_a = mid;
        div_req.op_b = dsel;
        if (!pend_q) begin
          div_req.start = 1'b1;
          pend_d = 1'b1;
        end else if (div_rsp.done) begin
          pend_d = 1'b0;
          acc_d  = (k_q < 3'd4) ? acc_q + div_rsp.res_a : acc_q - div_rsp.res_a;
          if (k_q == 3'd6) state_d = S_UPD;
          else k_d = k_q + 1'b1;
        end
      end
      S_UPD: begin
        lo_d  = nlo;
        hi_d  = nhi;
        k_d   = '0;
        acc_d = '0;
        if (nlo < nhi) begin
          state_d = S_DIV;
        end else begin
          res_d   = nlo;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_o.ready) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase

    if (store) begin
      case (lidx_q)
        2'd0:    ab_d  = lres;
        2'd1:    ac_d  = lres;
        2'd2:    bc_d  = lres;
        default: abc_d = lres;
      endcase
      if (lidx_q == 2'd3) begin
        k_d   = '0;
        acc_d = '0;
        if (lo_q < hi_q) begin
          state_d = S_DIV;
        end else begin
          res_d   = lo_q;
          state_d = S_OUT;
        end
      end else begin
        lidx_d  = lidx_q + 1'b1;
        gx_d    = pick_x(lidx_q + 1'b1, a_q, b_q, ab_d);
        gy_d    = pick_y(lidx_q + 1'b1, b_q, c_q);
        state_d = S_GCD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pend_q  <= 1'b0;
      lidx_q  <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      lidx_q  <= lidx_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d; b_q <= b_d; c_q <= c_d; n_q <= n_d;
    lo_q <= lo_d; hi_q <= hi_d; cap_q <= cap_d;
    ab_q <= ab_d; ac_q <= ac_d; bc_q <= bc_d; abc_q <= abc_d;
    gx_q <= gx_d; gy_q <= gy_d; qt_q <= qt_d; acc_q <= acc_d; res_q <= res_d;
  end
endmodule
